// ----- design/mse_pkg.sv -----
// Package for the MIPS subset execute unit: payload structs, decoded item,
// opcode constants and queue depths. No dependencies.
package mse_pkg;

   localparam int DATA_MEM_BYTES = 65536;
   localparam int NUM_REGS       = 32;
   localparam int REG_IDX_W      = 5;
   localparam int MID_DEPTH      = 2;
   localparam int OUT_DEPTH      = 4;

   localparam logic [5:0]  OP_SPECIAL = 6'h00;
   localparam logic [5:0]  OP_ADDIU   = 6'h09;
   localparam logic [5:0]  OP_LW      = 6'h23;
   localparam logic [5:0]  OP_SW      = 6'h2b;
   localparam logic [5:0]  FN_ADDU    = 6'h21;
   localparam logic [31:0] HALT_WORD  = 32'hffff_ffff;

   typedef enum logic [2:0] {
      CLS_NOP,
      CLS_ADDU,
      CLS_ADDIU,
      CLS_LW,
      CLS_SW,
      CLS_HALT,
      CLS_PRELOAD
   } op_class_type;

   typedef struct packed {
      logic        mode;
      logic [31:0] instruction;
      logic [15:0] load_address;
      logic [7:0]  load_byte;
   } req_type;

   typedef struct packed {
      logic        halted;
      logic [31:0] instr_address;
      logic        reg_write_valid;
      logic [4:0]  reg_write_index;
      logic [31:0] reg_write_value;
      logic        mem_write_valid;
      logic [15:0] mem_write_address;
      logic [31:0] mem_write_value;
   } rsp_type;

   typedef struct packed {
      op_class_type          cls;
      logic [REG_IDX_W-1:0]  rs;
      logic [REG_IDX_W-1:0]  rt;
      logic [REG_IDX_W-1:0]  dest;
      logic [15:0]           imm;
      logic [15:0]           load_address;
      logic [7:0]            load_byte;
   } dec_type;

endpackage

// ----- design/mse_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

// ----- design/mse_fifo.sv -----
// Small synchronous queue with an occupancy count, used between the front and
// back parts and on the result side. No package dependencies.
module mse_fifo #(
   parameter int  DEPTH     = 2,
   parameter type item_type = logic
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  item_type                   push_data,
   output logic                       full,
   input  logic                       pop,
   output item_type                   pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   item_type          slots_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];
   assign count    = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/mse_front.sv -----
// Front part: accepts request transfers and classifies each instruction word
// into a decoded item for the queue. Depends on mse_pkg.
module mse_front (
   input  logic             req_push,
   input  mse_pkg::req_type req_data,
   output logic             req_full,
   input  logic             queue_full,
   input  logic             clearing,
   output logic             queue_push,
   output mse_pkg::dec_type queue_data
);

   logic [5:0] opcode;
   logic [5:0] funct;

   assign opcode     = req_data.instruction[31:26];
   assign funct      = req_data.instruction[5:0];
   assign req_full   = queue_full || clearing;
   assign queue_push = req_push && !req_full;

   always_comb begin
      queue_data              = '0;
      queue_data.rs           = req_data.instruction[25:21];
      queue_data.rt           = req_data.instruction[20:16];
      queue_data.dest         = req_data.instruction[20:16];
      queue_data.imm          = req_data.instruction[15:0];
      queue_data.load_address = req_data.load_address;
      queue_data.load_byte    = req_data.load_byte;
      queue_data.cls          = mse_pkg::CLS_NOP;
      if (req_data.mode) begin
         queue_data.cls = mse_pkg::CLS_PRELOAD;
      end else if (req_data.instruction == mse_pkg::HALT_WORD) begin
         queue_data.cls = mse_pkg::CLS_HALT;
      end else begin
         case (opcode)
            mse_pkg::OP_SPECIAL: begin
               if (funct == mse_pkg::FN_ADDU) begin
                  queue_data.cls  = mse_pkg::CLS_ADDU;
                  queue_data.dest = req_data.instruction[15:11];
               end
            end
            mse_pkg::OP_ADDIU: begin
               queue_data.cls = mse_pkg::CLS_ADDIU;
            end
            mse_pkg::OP_LW: begin
               queue_data.cls = mse_pkg::CLS_LW;
            end
            mse_pkg::OP_SW: begin
               queue_data.cls = mse_pkg::CLS_SW;
            end
            default: begin
               queue_data.cls = mse_pkg::CLS_NOP;
            end
         endcase
      end
   end

endmodule

// ----- design/mse_back.sv -----
// Back part: register file, banked byte data memory, program counter and halt
// flag; issues decoded items and produces results. Depends on mse_pkg, mse_ram.
module mse_back #(
   parameter int DATA_MEM_BYTES = mse_pkg::DATA_MEM_BYTES
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  mse_pkg::dec_type                        item,
   input  logic                                    item_empty,
   output logic                                    item_pop,
   input  logic [$clog2(mse_pkg::OUT_DEPTH+1)-1:0] out_count,
   output logic                                    res_push,
   output mse_pkg::rsp_type                        res_data,
   output logic                                    clearing
);

   // Bytes are spread over four banks by the low two address bits, so every
   // word access touches each bank exactly once.
   localparam int AW   = $clog2(DATA_MEM_BYTES);
   localparam int RW   = AW - 2;
   localparam int ROWS = DATA_MEM_BYTES / 4;
   localparam int OCW  = $clog2(mse_pkg::OUT_DEPTH + 1);
   localparam int IW   = mse_pkg::REG_IDX_W;

   logic                      b_valid_ff, b_valid_in;
   mse_pkg::dec_type          b_item_ff;
   logic                      a_vld_ff, bv_vld_ff;
   logic                      fwd_we_ff;
   logic [IW-1:0]             fwd_idx_ff;
   logic [31:0]               fwd_data_ff;
   logic                      c_valid_ff, c_valid_in;
   logic [IW-1:0]             c_dest_ff;
   logic [1:0]                c_off_ff;
   logic [31:0]               c_pc_ff;
   logic [31:0]               pc_ff, pc_in;
   logic                      halt_ff, halt_in;
   logic                      clear_ff, clear_in;
   logic [RW-1:0]             clear_row_ff, clear_row_in;
   logic [mse_pkg::NUM_REGS-1:0] reg_valid_ff;

   logic [31:0]               rf_a_data, rf_b_data;
   logic                      rf_we;
   logic [IW-1:0]             rf_idx;
   logic [31:0]               rf_data;

   logic [31:0]               op_a, op_b, simm, ea, sum_ab, ea_wrapped, load_word;
   logic [1:0]                off;
   logic [RW-1:0]             base_row;
   logic [31:0]               laddr32;
   logic [AW-1:0]             pre_addr;
   logic [OCW:0]              occupancy;
   logic                      issue;

   logic                      bank_we    [4];
   logic [RW-1:0]             bank_waddr [4];
   logic [7:0]                bank_wdata [4];
   logic [RW-1:0]             bank_raddr [4];
   logic [7:0]                bank_rdata [4];
   logic [1:0]                slot       [4];

   assign clearing  = clear_ff;
   assign occupancy = (OCW+1)'(out_count) + (OCW+1)'(b_valid_ff) + (OCW+1)'(c_valid_ff);
   assign issue     = !clear_ff && !item_empty
                      && !(b_valid_ff && (b_item_ff.cls == mse_pkg::CLS_LW))
                      && (occupancy < (OCW+1)'(mse_pkg::OUT_DEPTH));
   assign item_pop   = issue;
   assign b_valid_in = issue;

   mse_ram #(.WIDTH(32), .DEPTH(mse_pkg::NUM_REGS)) u_rf_a (
      .clock(clock), .write_enable(rf_we), .write_address(rf_idx), .write_data(rf_data),
      .read_address(item.rs), .read_data(rf_a_data)
   );

   mse_ram #(.WIDTH(32), .DEPTH(mse_pkg::NUM_REGS)) u_rf_b (
      .clock(clock), .write_enable(rf_we), .write_address(rf_idx), .write_data(rf_data),
      .read_address(item.rt), .read_data(rf_b_data)
   );

   for (genvar k = 0; k < 4; k++) begin : g_bank
      mse_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
         .clock(clock), .write_enable(bank_we[k]), .write_address(bank_waddr[k]),
         .write_data(bank_wdata[k]), .read_address(bank_raddr[k]),
         .read_data(bank_rdata[k])
      );
   end

   always_comb begin
      op_a = (fwd_we_ff && (fwd_idx_ff == b_item_ff.rs)) ? fwd_data_ff
             : (a_vld_ff ? rf_a_data : '0);
      op_b = (fwd_we_ff && (fwd_idx_ff == b_item_ff.rt)) ? fwd_data_ff
             : (bv_vld_ff ? rf_b_data : '0);
      simm       = {{16{b_item_ff.imm[15]}}, b_item_ff.imm};
      ea         = op_a + simm;
      sum_ab     = op_a + op_b;
      ea_wrapped = ea & 32'(DATA_MEM_BYTES - 1);
      off        = ea[1:0];
      base_row   = ea[AW-1:2];
      laddr32    = 32'(b_item_ff.load_address);
      pre_addr   = laddr32[AW-1:0];
      for (int k = 0; k < 4; k++) begin
         slot[k]       = 2'(k) - off;
         bank_raddr[k] = (2'(k) < off) ? base_row + 1'b1 : base_row;
      end
      for (int i = 0; i < 4; i++) begin
         load_word[8*(3-i) +: 8] = bank_rdata[2'(c_off_ff + 2'(i))];
      end
   end

   always_comb begin
      res_data                 = '0;
      res_data.halted          = halt_ff;
      res_data.instr_address   = pc_ff;
      res_push                 = 1'b0;
      pc_in                    = pc_ff;
      halt_in                  = halt_ff;
      c_valid_in               = 1'b0;
      rf_we                    = 1'b0;
      rf_idx                   = b_item_ff.dest;
      rf_data                  = '0;
      clear_in                 = clear_ff;
      clear_row_in             = clear_row_ff;
      for (int k = 0; k < 4; k++) begin
         bank_we[k]    = 1'b0;
         bank_waddr[k] = bank_raddr[k];
         bank_wdata[k] = op_b[{~slot[k], 3'b000} +: 8];
      end

      if (clear_ff) begin
         clear_row_in = clear_row_ff + 1'b1;
         if (clear_row_ff == RW'(ROWS - 1)) begin
            clear_in = 1'b0;
         end
         for (int k = 0; k < 4; k++) begin
            bank_we[k]    = 1'b1;
            bank_waddr[k] = clear_row_ff;
            bank_wdata[k] = '0;
         end
      end

      if (b_valid_ff) begin
         if (b_item_ff.cls == mse_pkg::CLS_PRELOAD) begin
            res_push = 1'b1;
            for (int k = 0; k < 4; k++) begin
               if (pre_addr[1:0] == 2'(k)) begin
                  bank_we[k]    = 1'b1;
                  bank_waddr[k] = pre_addr[AW-1:2];
                  bank_wdata[k] = b_item_ff.load_byte;
               end
            end
         end else if (halt_ff) begin
            res_push = 1'b1;
         end else begin
            pc_in = pc_ff + 32'd4;
            case (b_item_ff.cls)
               mse_pkg::CLS_HALT: begin
                  pc_in           = pc_ff;
                  halt_in         = 1'b1;
                  res_data.halted = 1'b1;
                  res_push        = 1'b1;
               end
               mse_pkg::CLS_ADDU: begin
                  rf_data  = sum_ab;
                  rf_we    = (b_item_ff.dest != '0);
                  res_push = 1'b1;
               end
               mse_pkg::CLS_ADDIU: begin
                  rf_data  = ea;
                  rf_we    = (b_item_ff.dest != '0);
                  res_push = 1'b1;
               end
               mse_pkg::CLS_LW: begin
                  c_valid_in = 1'b1;
               end
               mse_pkg::CLS_SW: begin
                  for (int k = 0; k < 4; k++) begin
                     bank_we[k] = 1'b1;
                  end
                  res_data.mem_write_valid   = 1'b1;
                  res_data.mem_write_address = ea_wrapped[15:0];
                  res_data.mem_write_value   = op_b;
                  res_push                   = 1'b1;
               end
               default: begin
                  res_push = 1'b1;
               end
            endcase
            if (rf_we) begin
               res_data.reg_write_valid = 1'b1;
               res_data.reg_write_index = b_item_ff.dest;
               res_data.reg_write_value = rf_data;
            end
         end
      end

      if (c_valid_ff) begin
         res_data               = '0;
         res_data.instr_address = c_pc_ff;
         res_push               = 1'b1;
         rf_idx                 = c_dest_ff;
         rf_data                = load_word;
         rf_we                  = (c_dest_ff != '0);
         if (rf_we) begin
            res_data.reg_write_valid = 1'b1;
            res_data.reg_write_index = c_dest_ff;
            res_data.reg_write_value = load_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         fwd_we_ff    <= 1'b0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         clear_ff     <= 1'b1;
         clear_row_ff <= '0;
         reg_valid_ff <= '0;
      end else begin
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         fwd_we_ff    <= rf_we;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         clear_ff     <= clear_in;
         clear_row_ff <= clear_row_in;
         if (rf_we) begin
            reg_valid_ff[rf_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_vld_ff    <= reg_valid_ff[item.rs];
      bv_vld_ff   <= reg_valid_ff[item.rt];
      fwd_idx_ff  <= rf_idx;
      fwd_data_ff <= rf_data;
      if (issue) begin
         b_item_ff <= item;
      end
      if (c_valid_in) begin
         c_dest_ff <= b_item_ff.dest;
         c_off_ff  <= off;
         c_pc_ff   <= pc_ff;
      end
   end

endmodule

// ----- design/mips_subset_execute_unit.sv -----
// Top level of the MIPS subset execute unit: front part, decoded-item queue,
// back part and result queue. Depends on mse_pkg, mse_front, mse_fifo, mse_back.
//
//   Channel  Ports                        Direction  Transfer when
//   request  req_push, req_full, req_data  in         req_push && !req_full
//   result   rsp_pop, rsp_empty, rsp_data  out        rsp_pop && !rsp_empty
//
// An instruction normally issues from the queue each cycle; a load word holds
// issue while its data memory read completes. A request passes through the
// decoded-item queue and the issue register before its result enters the
// result queue; a load word also passes through a load register.
// After reset the data memory is cleared row by row, during which req_full is
// high. Results wait in a four-entry queue; the back part stops issuing when
// that queue and the instructions in flight would overfill.
module mips_subset_execute_unit #(
   parameter int DATA_MEM_BYTES = mse_pkg::DATA_MEM_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  mse_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output mse_pkg::rsp_type rsp_data
);

   logic                                    clearing;
   logic                                    mid_push, mid_full, mid_pop, mid_empty;
   mse_pkg::dec_type                        mid_in, mid_out;
   logic [$clog2(mse_pkg::MID_DEPTH+1)-1:0] mid_count;
   logic                                    out_push, out_full;
   mse_pkg::rsp_type                        out_in;
   logic [$clog2(mse_pkg::OUT_DEPTH+1)-1:0] out_count;

   mse_front u_front (
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .queue_full (mid_full),
      .clearing   (clearing),
      .queue_push (mid_push),
      .queue_data (mid_in)
   );

   mse_fifo #(.DEPTH(mse_pkg::MID_DEPTH), .item_type(mse_pkg::dec_type)) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   mse_back #(.DATA_MEM_BYTES(DATA_MEM_BYTES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (mid_out),
      .item_empty (mid_empty || (mid_count == '0)),
      .item_pop   (mid_pop),
      .out_count  (out_count),
      .res_push   (out_push),
      .res_data   (out_in),
      .clearing   (clearing)
   );

   mse_fifo #(.DEPTH(mse_pkg::OUT_DEPTH), .item_type(mse_pkg::rsp_type)) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push && !out_full),
      .push_data (out_in),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .count     (out_count)
   );

endmodule

// ----- design/mse_checker.sv -----
// Port-level checker for the MIPS subset execute unit, bound to the top level.
// Depends on mse_pkg and mips_subset_execute_unit.
module mse_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input mse_pkg::rsp_type rsp_data
);

   logic rsp_xfer;
   logic halt_seen_ff, halt_seen_in;

   assign rsp_xfer     = rsp_pop && !rsp_empty;
   assign halt_seen_in = halt_seen_ff || (rsp_xfer && rsp_data.halted);

   always_ff @(posedge clock) begin
      if (reset) begin
         halt_seen_ff <= 1'b0;
      end else begin
         halt_seen_ff <= halt_seen_in;
      end
   end

   a_reset_full: assert property (@(posedge clock) reset |=> req_full)
      else $error("request side not full after reset");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed before its transfer");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && halt_seen_ff) |-> rsp_data.halted)
      else $error("halted indication dropped after a halt");

   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_data.reg_write_valid) |-> (rsp_data.reg_write_index != '0))
      else $error("register zero reported as written");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> !(rsp_data.reg_write_valid && rsp_data.mem_write_valid))
      else $error("register and memory write in one result");

endmodule

bind mips_subset_execute_unit mse_checker u_checker (.*);

// ----- sim/mips_subset_execute_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for mips_subset_execute_unit. It depends on mse_pkg and the
// RTL only, and checks every result transfer against an in-bench model of the
// architectural state.
module mips_subset_execute_unit_tb;

   localparam logic [5:0] OP_ADDI = 6'h08;
   localparam logic [5:0] FN_ADD  = 6'h20;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_push  = 1'b0;
   logic             req_full;
   mse_pkg::req_type req_data  = '0;
   logic             rsp_empty;
   logic             rsp_pop   = 1'b0;
   mse_pkg::rsp_type rsp_data;

   logic [31:0] arch_gpr [mse_pkg::NUM_REGS];
   logic [7:0]  arch_mem [mse_pkg::DATA_MEM_BYTES];
   logic [31:0] arch_pc;
   bit          arch_halted;

   mse_pkg::rsp_type retire_queue [$];
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int items_sent      = 0;
   int preloads_sent   = 0;
   int results_checked = 0;
   int error_count     = 0;

   mips_subset_execute_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #5ns clock = ~clock;

   function automatic logic [31:0] mem_index(logic [31:0] addr);
      return addr % mse_pkg::DATA_MEM_BYTES;
   endfunction

   function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] shamt, logic [5:0] funct);
      return {mse_pkg::OP_SPECIAL, rs, rt, rd, shamt, funct};
   endfunction

   function automatic logic [31:0] enc_i(logic [5:0] opcode, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {opcode, rs, rt, imm};
   endfunction

   function automatic mse_pkg::rsp_type retire_instruction(mse_pkg::req_type item);
      mse_pkg::rsp_type res;
      logic [5:0]       opcode;
      logic [4:0]       rs;
      logic [4:0]       rt;
      logic [4:0]       dest;
      logic [31:0]      simm;
      logic [31:0]      ea;
      logic [31:0]      val;
      bit               wr;
      res = '0;
      res.instr_address = arch_pc;
      wr = 1'b0;
      dest = '0;
      val = '0;
      opcode = item.instruction[31:26];
      rs = item.instruction[25:21];
      rt = item.instruction[20:16];
      simm = {{16{item.instruction[15]}}, item.instruction[15:0]};
      ea = arch_gpr[rs] + simm;
      if (item.mode) begin
         arch_mem[mem_index(32'(item.load_address))] = item.load_byte;
      end else if (!arch_halted) begin
         if (item.instruction == mse_pkg::HALT_WORD) begin
            arch_halted = 1'b1;
         end else begin
            case (opcode)
               mse_pkg::OP_SPECIAL: begin
                  if (item.instruction[5:0] == mse_pkg::FN_ADDU) begin
                     wr = 1'b1;
                     dest = item.instruction[15:11];
                     val = arch_gpr[rs] + arch_gpr[rt];
                  end
               end
               mse_pkg::OP_ADDIU: begin
                  wr = 1'b1;
                  dest = rt;
                  val = arch_gpr[rs] + simm;
               end
               mse_pkg::OP_LW: begin
                  wr = 1'b1;
                  dest = rt;
                  for (int i = 0; i < 4; i++)
                     val = {val[23:0], arch_mem[mem_index(ea + i)]};
               end
               mse_pkg::OP_SW: begin
                  for (int i = 0; i < 4; i++)
                     arch_mem[mem_index(ea + i)] = arch_gpr[rt][8*(3-i) +: 8];
                  res.mem_write_valid = 1'b1;
                  res.mem_write_address = 16'(mem_index(ea));
                  res.mem_write_value = arch_gpr[rt];
               end
               default: ;
            endcase
            if (wr && dest != '0) begin
               arch_gpr[dest] = val;
               res.reg_write_valid = 1'b1;
               res.reg_write_index = dest;
               res.reg_write_value = val;
            end
            arch_pc = arch_pc + 32'd4;
         end
      end
      res.halted = arch_halted;
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d, %s: got %h, expected %h",
                                   results_checked, name, got, want));
   endtask

   always @(posedge clock) begin
      mse_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (retire_queue.size() == 0) begin
            report_mismatch("result transfer with no instruction outstanding");
         end else begin
            want = retire_queue.pop_front();
            check_field("halted", rsp_data.halted, want.halted);
            check_field("instr_address", rsp_data.instr_address, want.instr_address);
            check_field("reg_write_valid", rsp_data.reg_write_valid, want.reg_write_valid);
            check_field("reg_write_index", rsp_data.reg_write_index, want.reg_write_index);
            check_field("reg_write_value", rsp_data.reg_write_value, want.reg_write_value);
            check_field("mem_write_valid", rsp_data.mem_write_valid, want.mem_write_valid);
            check_field("mem_write_address", rsp_data.mem_write_address,
                        want.mem_write_address);
            check_field("mem_write_value", rsp_data.mem_write_value, want.mem_write_value);
            results_checked++;
         end
      end
      rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_item(mse_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      retire_queue.push_back(retire_instruction(item));
      items_sent++;
   endtask

   task automatic send_instr(logic [31:0] word);
      mse_pkg::req_type item;
      item.mode = 1'b0;
      item.instruction = word;
      item.load_address = 16'($urandom);
      item.load_byte = 8'($urandom);
      send_item(item);
   endtask

   task automatic send_preload(logic [15:0] addr, logic [7:0] value);
      mse_pkg::req_type item;
      item.mode = 1'b1;
      item.instruction = $urandom;
      item.load_address = addr;
      item.load_byte = value;
      send_item(item);
      preloads_sent++;
   endtask

   task automatic test_register_arith();
      send_idle_pct = 0;
      stall_pct = 0;
      send_instr(enc_i(mse_pkg::OP_ADDIU, 0, 1, 16'hffff));
      send_instr(enc_r(1, 1, 2, 0, mse_pkg::FN_ADDU));
      send_instr(enc_i(mse_pkg::OP_ADDIU, 0, 3, 16'h7fff));
      send_instr(enc_i(mse_pkg::OP_ADDIU, 3, 4, 16'h8000));
      send_instr(enc_r(3, 4, 31, 5'h1f, mse_pkg::FN_ADDU));
      send_instr(enc_i(mse_pkg::OP_ADDIU, 1, 0, 16'h1234));
      send_instr(enc_r(1, 2, 0, 0, mse_pkg::FN_ADDU));
   endtask

   task automatic test_memory_access();
      send_preload(16'hffff, 8'hff);
      send_preload(16'h0000, 8'h5a);
      send_instr(enc_i(mse_pkg::OP_LW, 0, 5, 16'hfffd));
      send_instr(enc_i(mse_pkg::OP_SW, 0, 1, 16'hfffe));
      send_instr(enc_i(mse_pkg::OP_LW, 0, 6, 16'hffff));
      send_instr(enc_i(mse_pkg::OP_SW, 1, 3, 16'h0005));
      send_instr(enc_i(mse_pkg::OP_LW, 1, 0, 16'h0005));
      send_instr(enc_i(mse_pkg::OP_LW, 0, 7, 16'h0003));
      send_instr(enc_i(mse_pkg::OP_SW, 0, 0, 16'h7fff));
   endtask

   task automatic test_unknown_encodings();
      send_instr(32'h0000_0000);
      send_instr(enc_r(1, 2, 3, 0, FN_ADD));
      send_instr(32'hffff_fffe);
      send_instr(enc_i(OP_ADDI, 1, 9, 16'h0001));
   endtask

   task automatic test_random(int count, int idle_pct, int stall);
      int unsigned pick;
      logic [15:0] addr;
      logic [4:0]  base;
      logic [31:0] word;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      repeat (count) begin
         pick = $urandom_range(99);
         // Most memory traffic stays in two small windows at either end of the
         // address space, so that loads see earlier stores and wrapping occurs.
         addr = ($urandom_range(3) == 0) ? 16'($urandom)
                                         : {{10{$urandom_range(1) == 1}}, 6'($urandom)};
         if (pick < 10) begin
            send_preload(addr, 8'($urandom));
         end else begin
            if (pick < 30) begin
               word = enc_r(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                            mse_pkg::FN_ADDU);
            end else if (pick < 50) begin
               word = enc_i(mse_pkg::OP_ADDIU, 5'($urandom), 5'($urandom),
                            $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(15)));
            end else if (pick < 90) begin
               base = ($urandom_range(3) == 0) ? 5'($urandom) : 5'd0;
               word = enc_i((pick < 70) ? mse_pkg::OP_LW : mse_pkg::OP_SW, base,
                            5'($urandom), (base == 0) ? addr : 16'($urandom));
            end else if (pick < 95) begin
               word = enc_r(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                            6'($urandom));
            end else begin
               word = $urandom;
               if (word == mse_pkg::HALT_WORD)
                  word = '0;
            end
            send_instr(word);
         end
      end
   endtask

   task automatic test_halt();
      send_idle_pct = 33;
      stall_pct = 33;
      send_instr(enc_i(mse_pkg::OP_ADDIU, 0, 8, 16'h0042));
      send_instr(mse_pkg::HALT_WORD);
      send_instr(enc_i(mse_pkg::OP_ADDIU, 0, 9, 16'h0001));
      send_instr(enc_i(mse_pkg::OP_SW, 0, 1, 16'h0000));
      send_preload(16'h0100, 8'h33);
      send_instr(mse_pkg::HALT_WORD);
   endtask

   initial begin
      for (int i = 0; i < mse_pkg::NUM_REGS; i++)
         arch_gpr[i] = '0;
      for (int i = 0; i < mse_pkg::DATA_MEM_BYTES; i++)
         arch_mem[i] = '0;
      arch_pc = '0;
      arch_halted = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_register_arith();
      test_memory_access();
      test_unknown_encodings();
      test_random(150, 0, 0);
      test_random(150, 69, 0);
      test_random(150, 0, 69);
      test_random(150, 33, 33);
      test_halt();
      req_push <= 1'b0;
      while (retire_queue.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      $display("Covered addu, addiu, lw, sw, unknown encodings, r0 writes, address wrap,");
      $display("preloads and halt: %0d transfers in (%0d preloads), %0d results checked.",
               items_sent, preloads_sent, results_checked);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2ms;
      $display("Timed out with %0d results outstanding.", retire_queue.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/mse_pkg.sv
design/mse_ram.sv
design/mse_fifo.sv
design/mse_front.sv
design/mse_back.sv
design/mips_subset_execute_unit.sv
design/mse_checker.sv
sim/mips_subset_execute_unit_tb.sv
